// ===== hdl/bpfa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bpfa_pkg;
  localparam int MAX_FRAMES_DEF        = 32768;
  localparam int PAGE_SHIFT_DEF        = 12;
  localparam int FIRST_ALLOC_FRAME_DEF = 256;

  localparam int ADDR_W   = 32;
  localparam int FRAME_W  = 16;
  localparam int OUTA_W   = 27;
  localparam int WORD_W   = 32;
  localparam int WCNT_W   = 12;

  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_FREE    = 2'd1;
  localparam logic [1:0] ACT_RESERVE = 2'd2;
  localparam logic [1:0] ACT_RELEASE = 2'd3;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NO_FRAME = 2'd1;
  localparam logic [1:0] ST_IGNORED  = 2'd2;

  localparam int REG_TRACKED = 0;
endpackage
`default_nettype wire

// ===== hdl/bpfa_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface bpfa_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  action;
  logic [bpfa_pkg::ADDR_W-1:0] start_address;
  logic [bpfa_pkg::ADDR_W-1:0] end_address;
  modport source (output valid, action, start_address, end_address, input ready);
  modport sink (input valid, action, start_address, end_address, output ready);
endinterface
`default_nettype wire

// ===== hdl/bpfa_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface bpfa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bpfa_pkg::OUTA_W-1:0]  frame_address;
  logic [1:0]                   status;
  logic [bpfa_pkg::FRAME_W-1:0] free_frames;
  logic [bpfa_pkg::FRAME_W-1:0] used_frames;
  modport source (output valid, frame_address, status, free_frames, used_frames,
                  input ready);
  modport sink (input valid, frame_address, status, free_frames, used_frames,
                output ready);
endinterface
`default_nettype wire

// ===== hdl/bitmap_page_frame_allocator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// First-fit page frame allocator over a used/free bitmap held in one synchronous
// word memory (MAX_FRAMES/32 words of 32 bits). After reset a clearing pass writes
// every word to all ones, one word at a time; no item is taken meanwhile, register
// writes are. Each item then reads, modifies and writes back one bitmap word at a
// time (states S_RD, S_EX): an allocate scans words from FIRST_ALLOC_FRAME up to
// the first free frame, a range reserve or release touches each word in its range,
// a single free touches one word, and an ignored free or an empty range none.
// Accept, finish and result take the states S_IDLE, S_DONE and S_FIN. The result
// waits in an output register while the next item is accepted.
module bitmap_page_frame_allocator_core #(
  parameter int PAGE_SHIFT        = bpfa_pkg::PAGE_SHIFT_DEF,
  parameter int FIRST_ALLOC_FRAME = bpfa_pkg::FIRST_ALLOC_FRAME_DEF
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        psel,
  input  wire        penable,
  input  wire        pwrite,
  input  wire [2:0]  paddr,
  input  wire [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready,
  bpfa_req_if.sink   req,
  bpfa_rsp_if.source rsp
);
  localparam int MAX_FRAMES = bpfa_pkg::MAX_FRAMES_DEF;
  localparam int MAP_WORDS = (MAX_FRAMES + 31) / 32;
  localparam int WIW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int FW        = bpfa_pkg::FRAME_W;
  localparam int CW        = bpfa_pkg::WCNT_W;
  localparam logic [CW-1:0] START_W = CW'(FIRST_ALLOC_FRAME / 32);
  localparam logic [31:0] SKIP_MASK = (32'd1 << (FIRST_ALLOC_FRAME % 32)) - 32'd1;
  localparam logic [32:0] PAGE_M1   = (33'd1 << PAGE_SHIFT) - 33'd1;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EX   = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [31:0]    mem [MAP_WORDS];
  logic [31:0]    rdata;
  logic           we;
  logic [WIW-1:0] waddr;
  logic [31:0]    wdata;

  logic [2:0]     state;
  logic [WIW-1:0] clr;
  logic [FW-1:0]  tracked;
  logic [FW-1:0]  total;
  logic [CW-1:0]  wcnt, lo_w, hi_w;
  logic [4:0]     lo_b, hi_b;
  logic           set_op, is_alloc;
  logic [1:0]     status;
  logic [bpfa_pkg::OUTA_W-1:0] addr_r;
  logic [31:0]    chg;
  logic           chg_v;
  logic [FW-1:0]  cnt;

  logic [32:0] lo33, last33, hi33;
  logic [32:0] tot33;
  logic [16:0] hi_m1;
  logic [31:0] masked, rmask, nword;
  logic [4:0]  zbit;
  logic [16:0] frame;
  logic [5:0]  pc;
  logic [16:0] sum;
  logic [CW-1:0] wend;

  function automatic logic [bpfa_pkg::OUTA_W-1:0] OUTA_W_SEL(input logic [16:0] f);
    logic [39:0] a;
    a = 40'(f) << PAGE_SHIFT;
    return a[bpfa_pkg::OUTA_W-1:0];
  endfunction

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, tracked} : 32'd0;
  assign req.ready = (state == S_IDLE);
  assign total = (32'(tracked) > 32'(MAX_FRAMES)) ? FW'(MAX_FRAMES) : tracked;
  assign tot33 = 33'(total);
  assign wend  = CW'((17'(total) + 17'd31) >> 5);

  always_comb begin
    if (req.action == bpfa_pkg::ACT_RESERVE) begin
      lo33   = 33'(req.start_address) >> PAGE_SHIFT;
      last33 = (33'(req.end_address) + PAGE_M1) >> PAGE_SHIFT;
    end else if (req.action == bpfa_pkg::ACT_RELEASE) begin
      lo33   = (33'(req.start_address) + PAGE_M1) >> PAGE_SHIFT;
      last33 = 33'(req.end_address) >> PAGE_SHIFT;
    end else begin
      lo33   = 33'(req.start_address) >> PAGE_SHIFT;
      last33 = lo33 + 33'd1;
    end
    hi33  = (last33 < tot33) ? last33 : tot33;
    hi_m1 = 17'(hi33) - 17'd1;
  end

  always_comb begin
    masked = rdata | ((wcnt == START_W) ? SKIP_MASK : 32'd0);
    zbit = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (!masked[i]) zbit = 5'(i);
    end
    frame = {wcnt[11:0], zbit} - 17'd0;
    rmask = ({32{1'b1}} << ((wcnt == lo_w) ? lo_b : 5'd0))
          & ({32{1'b1}} >> (5'd31 - ((wcnt == hi_w) ? hi_b : 5'd31)));
    nword = set_op ? (rdata | rmask) : (rdata & ~rmask);
  end

  always_comb begin
    we    = 1'b0;
    waddr = WIW'(wcnt);
    wdata = nword;
    if (state == S_CLR) begin
      we    = 1'b1;
      waddr = clr;
      wdata = {32{1'b1}};
    end else if (state == S_EX) begin
      if (is_alloc) begin
        we    = (masked != {32{1'b1}}) && (32'(frame) < 32'(total));
        wdata = rdata | (32'd1 << zbit);
      end else begin
        we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (state == S_RD) rdata <= mem[WIW'(wcnt)];
  end

  assign pc  = 6'($countones(chg));
  assign sum = 17'(cnt) + 17'(pc);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr       <= '0;
      tracked   <= '0;
      cnt       <= '0;
      chg_v     <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr[2] == 1'b0) tracked <= pwdata[15:0];
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      chg_v <= (state == S_EX) && we;
      if (chg_v) begin
        if (set_op) cnt <= (cnt > FW'(pc)) ? cnt - FW'(pc) : '0;
        else cnt <= (sum > 17'hFFFF) ? 16'hFFFF : sum[15:0];
      end
      case (state)
        S_CLR: begin
          clr <= clr + 1'b1;
          if (clr == WIW'(MAP_WORDS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid) begin
            addr_r   <= '0;
            is_alloc <= (req.action == bpfa_pkg::ACT_ALLOC);
            set_op   <= (req.action == bpfa_pkg::ACT_ALLOC) ||
                        (req.action == bpfa_pkg::ACT_RESERVE);
            lo_w     <= CW'(lo33 >> 5);
            lo_b     <= lo33[4:0];
            hi_w     <= (req.action == bpfa_pkg::ACT_ALLOC) ? wend : CW'(hi_m1 >> 5);
            hi_b     <= hi_m1[4:0];
            if (req.action == bpfa_pkg::ACT_ALLOC) begin
              wcnt <= START_W;
              if (START_W >= wend) begin
                status <= bpfa_pkg::ST_NO_FRAME;
                state  <= S_DONE;
              end else begin
                status <= bpfa_pkg::ST_DONE;
                state  <= S_RD;
              end
            end else begin
              wcnt <= CW'(lo33 >> 5);
              if (req.action == bpfa_pkg::ACT_FREE &&
                  (lo33 == 33'd0 || lo33 >= tot33)) begin
                status <= bpfa_pkg::ST_IGNORED;
                state  <= S_DONE;
              end else begin
                status <= bpfa_pkg::ST_DONE;
                state  <= (lo33 >= hi33) ? S_DONE : S_RD;
              end
            end
          end
        end
        S_RD: state <= S_EX;
        S_EX: begin
          if (is_alloc) begin
            if (masked != {32{1'b1}}) begin
              if (32'(frame) < 32'(total)) begin
                chg    <= 32'd1 << zbit;
                addr_r <= OUTA_W_SEL(frame);
              end else status <= bpfa_pkg::ST_NO_FRAME;
              state <= S_DONE;
            end else if (wcnt + 1'b1 >= hi_w) begin
              status <= bpfa_pkg::ST_NO_FRAME;
              state  <= S_DONE;
            end else begin
              wcnt  <= wcnt + 1'b1;
              state <= S_RD;
            end
          end else begin
            chg <= set_op ? (rmask & ~rdata) : (rmask & rdata);
            if (wcnt == hi_w) state <= S_DONE;
            else begin
              wcnt  <= wcnt + 1'b1;
              state <= S_RD;
            end
          end
        end
        S_DONE: state <= S_FIN;
        S_FIN: begin
          if (!rsp.valid) begin
            rsp.valid         <= 1'b1;
            rsp.frame_address <= addr_r;
            rsp.status        <= status;
            rsp.free_frames   <= cnt;
            rsp.used_frames   <= (total > cnt) ? total - cnt : '0;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== dv/bpfa_alloc_checker.sv =====
`timescale 1ns / 1ps
module bpfa_alloc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  bpfa_req_if         req,
  bpfa_rsp_if         rsp,
  output int          errors,
  output int          pending,
  output int          checked
);
  import bpfa_pkg::*;

  localparam int MAP_WORDS = MAX_FRAMES_DEF / WORD_W;
  localparam longint unsigned PAGE_BYTES = 64'd1 << PAGE_SHIFT_DEF;

  typedef struct packed {
    logic [OUTA_W-1:0]  frame_address;
    logic [1:0]         status;
    logic [FRAME_W-1:0] free_frames;
    logic [FRAME_W-1:0] used_frames;
  } alloc_result_t;

  logic [WORD_W-1:0]  occupancy [MAP_WORDS];
  logic [FRAME_W-1:0] free_tally;
  logic [FRAME_W-1:0] tracked_reg;
  alloc_result_t      expected_results [$];

  function automatic int unsigned managed_frames();
    return (tracked_reg > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : tracked_reg;
  endfunction

  function automatic void claim_frame(int unsigned f);
    if (!occupancy[f / WORD_W][f % WORD_W]) begin
      occupancy[f / WORD_W][f % WORD_W] = 1'b1;
      if (free_tally > 0) free_tally--;
    end
  endfunction

  function automatic void return_frame(int unsigned f);
    if (occupancy[f / WORD_W][f % WORD_W]) begin
      occupancy[f / WORD_W][f % WORD_W] = 1'b0;
      if (free_tally < 16'hFFFF) free_tally++;
    end
  endfunction

  function automatic bit first_free_frame(int unsigned total, output int unsigned found);
    int unsigned wend;
    int unsigned bitpos;
    found = 0;
    wend = (total + 31) / 32;
    for (int unsigned w = FIRST_ALLOC_FRAME_DEF / WORD_W; w < wend && w < MAP_WORDS; w++) begin
      if (occupancy[w] != '1) begin
        bitpos = 0;
        while (occupancy[w][bitpos]) bitpos++;
        if (w * WORD_W + bitpos >= total) return 1'b0;
        found = w * WORD_W + bitpos;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic alloc_result_t apply_action(logic [1:0] act, logic [31:0] sa,
                                                 logic [31:0] ea);
    alloc_result_t r;
    int unsigned total;
    int unsigned fr;
    longint unsigned f;
    longint unsigned last;
    total = managed_frames();
    r = '0;
    r.status = ST_DONE;
    case (act)
      ACT_ALLOC: begin
        if (first_free_frame(total, fr)) begin
          claim_frame(fr);
          r.frame_address = OUTA_W'(longint'(fr) << PAGE_SHIFT_DEF);
        end else begin
          r.status = ST_NO_FRAME;
        end
      end
      ACT_FREE: begin
        f = longint'(sa) >> PAGE_SHIFT_DEF;
        if (f == 0 || f >= total) r.status = ST_IGNORED;
        else return_frame(int'(f));
      end
      ACT_RESERVE: begin
        f = longint'(sa) >> PAGE_SHIFT_DEF;
        last = (longint'(ea) + PAGE_BYTES - 1) >> PAGE_SHIFT_DEF;
        for (; f < last && f < total; f++) claim_frame(int'(f));
      end
      default: begin
        f = (longint'(sa) + PAGE_BYTES - 1) >> PAGE_SHIFT_DEF;
        last = longint'(ea) >> PAGE_SHIFT_DEF;
        for (; f < last && f < total; f++) return_frame(int'(f));
      end
    endcase
    r.free_frames = free_tally;
    r.used_frames = (total > free_tally) ? FRAME_W'(total - free_tally) : '0;
    return r;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
    checked = 0;
  end

  always @(posedge clk) begin
    alloc_result_t want;
    if (rst) begin
      for (int w = 0; w < MAP_WORDS; w++) occupancy[w] = '1;
      free_tally = '0;
      tracked_reg = '0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == 3'(REG_TRACKED * 4))
        tracked_reg = pwdata[FRAME_W-1:0];
      if (rsp.valid && rsp.ready) begin
        checked++;
        if (expected_results.size() == 0) begin
          $error("result with no item pending: addr %h status %0d", rsp.frame_address,
                 rsp.status);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (rsp.frame_address !== want.frame_address) begin
            $error("frame_address expected %h actual %h", want.frame_address,
                   rsp.frame_address);
            errors++;
          end
          if (rsp.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, rsp.status);
            errors++;
          end
          if (rsp.free_frames !== want.free_frames) begin
            $error("free_frames expected %0d actual %0d", want.free_frames, rsp.free_frames);
            errors++;
          end
          if (rsp.used_frames !== want.used_frames) begin
            $error("used_frames expected %0d actual %0d", want.used_frames, rsp.used_frames);
            errors++;
          end
        end
      end
      if (req.valid && req.ready)
        expected_results.push_back(apply_action(req.action, req.start_address,
                                                req.end_address));
    end
    pending = expected_results.size();
  end
endmodule

// ===== dv/tb_bitmap_page_frame_allocator_core.sv =====
`timescale 1ns / 1ps
module tb_bitmap_page_frame_allocator_core;
  import bpfa_pkg::*;

  localparam int ITEMS_PER_PHASE = 125;
  localparam int STALL_LIMIT = 60000;
  localparam logic [2:0] ADDR_TRACKED = 3'(REG_TRACKED * 4);
  localparam logic [2:0] ADDR_UNUSED = 3'((REG_TRACKED + 1) * 4);
  localparam logic [31:0] PAGE = 32'd1 << PAGE_SHIFT_DEF;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          pending;
  int          checked;
  int          sent;
  int          cfg_writes;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          quiet_cycles;
  int unsigned tracked;

  bpfa_req_if req ();
  bpfa_rsp_if rsp ();

  bitmap_page_frame_allocator_core u_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req(req), .rsp(rsp)
  );

  bpfa_alloc_checker u_checker (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .pready(pready), .paddr(paddr), .pwdata(pwdata), .req(req), .rsp(rsp),
    .errors(errors), .pending(pending), .checked(checked)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(negedge clk) begin
    rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    cfg_writes++;
  endtask

  task automatic drain();
    @(negedge clk);
    req.valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_tracked(input int unsigned count);
    drain();
    reg_write(ADDR_TRACKED, count);
    tracked = count;
  endtask

  task automatic send(input logic [1:0] act, input logic [31:0] sa, input logic [31:0] ea);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.valid = 1'b1;
    req.action = act;
    req.start_address = sa;
    req.end_address = ea;
    do @(posedge clk); while (!req.ready);
    sent++;
  endtask

  function automatic int unsigned pick_frame();
    int unsigned lim;
    lim = (tracked > 2048) ? 2048 : tracked + 8;
    if ($urandom_range(9) == 0) lim = tracked + 64;
    return $urandom_range(lim);
  endfunction

  task automatic random_item();
    int unsigned sel;
    int unsigned f;
    logic [31:0] sa;
    logic [31:0] ea;
    sel = $urandom_range(99);
    f = pick_frame();
    sa = f * PAGE + ($urandom_range(3) == 0 ? $urandom_range(PAGE - 1) : 0);
    ea = sa + $urandom_range(12) * PAGE + ($urandom_range(3) == 0 ? $urandom_range(PAGE - 1) : 0);
    if ($urandom_range(19) == 0) begin
      sa = $urandom;
      ea = $urandom;
    end
    if (sel < 35) send(ACT_ALLOC, $urandom, $urandom);
    else if (sel < 60) send(ACT_FREE, sa, $urandom);
    else if (sel < 80) send(ACT_RESERVE, sa, ea);
    else send(ACT_RELEASE, sa, ea);
  endtask

  initial begin
    int unsigned phase_tracked [6];
    phase_tracked = '{1024, 300, 32768, 256, 4096, 600};
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req.valid = 1'b0;
    req.action = ACT_ALLOC;
    req.start_address = '0;
    req.end_address = '0;
    rsp.ready = 1'b0;
    sent = 0;
    cfg_writes = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    tracked = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send(ACT_ALLOC, 32'h0, 32'h0);
    send(ACT_FREE, 32'h0010_0000, 32'h0);
    drain();
    reg_write(ADDR_UNUSED, 32'hFFFF_FFFF);
    set_tracked(1024);
    send(ACT_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(ACT_RELEASE, 32'h0000_0001, 32'h0040_0000);
    send(ACT_FREE, 32'h0000_0FFF, 32'h0);
    send(ACT_FREE, 32'hFFFF_FFFF, 32'h0);
    send(ACT_ALLOC, 32'h0, 32'h0);
    send(ACT_FREE, 32'h0010_0000, 32'h0);
    send(ACT_FREE, 32'h0010_0000, 32'h0);
    send(ACT_RESERVE, 32'h0010_0FFF, 32'h0010_1001);
    send(ACT_RESERVE, 32'h0020_0000, 32'h0010_0000);
    send(ACT_RELEASE, 32'h0010_0001, 32'h0010_1FFF);
    send(ACT_RELEASE, 32'hFFFF_F001, 32'hFFFF_FFFF);
    send(ACT_RESERVE, 32'h0010_0000, 32'hFFFF_FFFF);
    send(ACT_ALLOC, 32'h0, 32'h0);
    send(ACT_RELEASE, 32'h0000_1000, 32'h0010_0000);
    send(ACT_ALLOC, 32'h0, 32'h0);
    set_tracked(100);
    send(ACT_FREE, 32'h0000_2000, 32'h0);
    send(ACT_ALLOC, 32'h0, 32'h0);
    set_tracked(32768);
    send(ACT_RELEASE, 32'h07FF_F000, 32'hFFFF_FFFF);
    send(ACT_ALLOC, 32'h0, 32'h0);
    send(ACT_FREE, 32'h07FF_F000, 32'h0);
    set_tracked(0);
    send(ACT_RELEASE, 32'h0, 32'hFFFF_FFFF);
    send(ACT_ALLOC, 32'h0, 32'h0);
    drain();

    for (int p = 0; p < 6; p++) begin
      set_tracked(phase_tracked[p]);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        case ((i * 4) / ITEMS_PER_PHASE)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
          default: begin send_idle_pct = 8; recv_stall_pct = 8; end
        endcase
        random_item();
      end
    end

    drain();
    repeat (40) @(posedge clk);
    $display("covered %0d items, %0d results checked, %0d register writes", sent, checked,
             cfg_writes);
    $display("tracked counts 0 to 32768, all four actions, sender and receiver stalls");
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
